// ===== hw/rtl/mbsc_pkg.sv =====
// mbsc_pkg: shared types, constants and helpers for the mosaic box shift/clip block
// no dependencies; used by every other file of the block
`default_nettype none
package mbsc_pkg;

  // fixed point format and field widths
  localparam int FRAC_BITS     = 16;
  localparam int QW            = FRAC_BITS + 2;       // signed Q2.F internal value
  localparam int FW            = 17;                  // box field width
  localparam int CLSW          = 16;
  localparam int DIMW          = 13;                  // tile size / offset registers
  localparam int CNTW          = 8;                   // slot counters
  localparam int SLOTW         = 7;
  localparam int EW            = 17;                  // pixel edge, signed
  localparam int NW            = 17;                  // divider numerator before scaling
  localparam int TW            = QW + 2;              // 2c +/- s
  localparam int PW            = TW + DIMW + 1;       // edge product
  localparam int MAG_W         = 15;                  // numerator magnitude
  localparam int DVD_W         = MAG_W + FRAC_BITS;   // dividend
  localparam int DVS_W         = DIMW + 1;            // divisor (up to 2 * dim)
  localparam int QUO_W         = DVD_W + 1;           // signed quotient
  localparam int SUM_W         = QUO_W + 1;
  localparam int DCNT_W        = $clog2(DVD_W);
  localparam int MAX_BOXES_DEF = 128;
  localparam int PADDR_W       = 5;
  localparam int PDATA_W       = 32;

  localparam logic signed [QW-1:0]    ONE_Q    = QW'(1 << FRAC_BITS);
  localparam logic signed [SUM_W-1:0] SAT_HI   = SUM_W'((1 << (QW - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO   = -SUM_W'(1 << (QW - 1));
  localparam logic signed [PW-1:0]    EDGE_RND = PW'((1 << (FRAC_BITS + 1)) - 1);

  // register reset values
  localparam logic [DIMW-1:0] IMG_W_RST = DIMW'(416);
  localparam logic [DIMW-1:0] IMG_H_RST = DIMW'(416);
  localparam logic [DIMW-1:0] CUT_RST   = DIMW'(208);

  typedef enum logic [2:0] {
    REG_IMG_W    = 3'd0,
    REG_IMG_H    = 3'd1,
    REG_CUT_COL  = 3'd2,
    REG_CUT_ROW  = 3'd3,
    REG_QUADRANT = 3'd4,
    REG_X_SHIFT  = 3'd5,
    REG_Y_SHIFT  = 3'd6,
    REG_EXISTING = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    STAT_KEEP   = 2'd0,
    STAT_DROP   = 2'd1,
    STAT_IGNORE = 2'd2
  } status_t;

  typedef struct packed {
    logic [DIMW-1:0] img_w;
    logic [DIMW-1:0] img_h;
    logic [DIMW-1:0] cut_col;
    logic [DIMW-1:0] cut_row;
    logic [1:0]      quadrant;
    logic [DIMW-1:0] x_shift;
    logic [DIMW-1:0] y_shift;
    logic [CNTW-1:0] existing_count;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [QUO_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OFF,
    ST_LO,
    ST_HI,
    ST_FLO_C,
    ST_FLO_S,
    ST_FHI_C,
    ST_FHI_S,
    ST_CHK_LO,
    ST_CHK_HI,
    ST_OUT
  } st_t;

  function automatic logic signed [QW-1:0] satq(input logic signed [SUM_W-1:0] v);
    logic signed [QW-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[QW-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[QW-1:0];
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/mbsc_if.sv =====
// mbsc_in_if / mbsc_out_if: valid/ready channels for box requests and results
// depends on mbsc_pkg
`default_nettype none
interface mbsc_in_if import mbsc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            start_list;
  logic [FW-1:0]   box_x;
  logic [FW-1:0]   box_y;
  logic [FW-1:0]   box_w;
  logic [FW-1:0]   box_h;
  logic [CLSW-1:0] box_class;

  modport source(output valid, start_list, box_x, box_y, box_w, box_h, box_class,
                 input ready);
  modport sink(input valid, start_list, box_x, box_y, box_w, box_h, box_class,
               output ready);
endinterface

interface mbsc_out_if import mbsc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [SLOTW-1:0] slot;
  logic [FW-1:0]    out_x;
  logic [FW-1:0]    out_y;
  logic [FW-1:0]    out_w;
  logic [FW-1:0]    out_h;
  logic [CLSW-1:0]  out_class;

  modport source(output valid, status, slot, out_x, out_y, out_w, out_h, out_class,
                 input ready);
  modport sink(input valid, status, slot, out_x, out_y, out_w, out_h, out_class,
               output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mbsc_regs.sv =====
// mbsc_regs: apb-style configuration registers of the box shift/clip block
// depends on mbsc_pkg
`default_nettype none
module mbsc_regs import mbsc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.img_w          <= IMG_W_RST;
      cfg_r.img_h          <= IMG_H_RST;
      cfg_r.cut_col        <= CUT_RST;
      cfg_r.cut_row        <= CUT_RST;
      cfg_r.quadrant       <= '0;
      cfg_r.x_shift        <= '0;
      cfg_r.y_shift        <= '0;
      cfg_r.existing_count <= '0;
    end else if (wr) begin
      case (idx)
        REG_IMG_W:    cfg_r.img_w          <= pwdata[DIMW-1:0];
        REG_IMG_H:    cfg_r.img_h          <= pwdata[DIMW-1:0];
        REG_CUT_COL:  cfg_r.cut_col        <= pwdata[DIMW-1:0];
        REG_CUT_ROW:  cfg_r.cut_row        <= pwdata[DIMW-1:0];
        REG_QUADRANT: cfg_r.quadrant       <= pwdata[1:0];
        REG_X_SHIFT:  cfg_r.x_shift        <= pwdata[DIMW-1:0];
        REG_Y_SHIFT:  cfg_r.y_shift        <= pwdata[DIMW-1:0];
        REG_EXISTING: cfg_r.existing_count <= pwdata[CNTW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_IMG_W:    prdata = PDATA_W'(cfg_r.img_w);
      REG_IMG_H:    prdata = PDATA_W'(cfg_r.img_h);
      REG_CUT_COL:  prdata = PDATA_W'(cfg_r.cut_col);
      REG_CUT_ROW:  prdata = PDATA_W'(cfg_r.cut_row);
      REG_QUADRANT: prdata = PDATA_W'(cfg_r.quadrant);
      REG_X_SHIFT:  prdata = PDATA_W'(cfg_r.x_shift);
      REG_Y_SHIFT:  prdata = PDATA_W'(cfg_r.y_shift);
      REG_EXISTING: prdata = PDATA_W'(cfg_r.existing_count);
      default:      prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/mbsc_div.sv =====
// mbsc_div: restoring divider, one quotient bit per cycle, sign applied at the end
// depends on mbsc_pkg
`default_nettype none
module mbsc_div import mbsc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic              busy_r;
  logic              done_r;
  logic              neg_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVD_W-1:0]  quo_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [DVS_W:0]    sh;
  logic [DVS_W+1:0]  diff;
  logic [QUO_W-1:0]  quo_ext;

  assign sh      = {rem_r, quo_r[DVD_W-1]};
  assign diff    = {1'b0, sh} - {2'b00, dvs_r};
  assign quo_ext = {1'b0, quo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == DCNT_W'(DVD_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt_r <= '0;
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
      neg_r <= req.neg;
    end else if (busy_r) begin
      cnt_r <= cnt_r + DCNT_W'(1);
      if (!diff[DVS_W+1]) begin
        rem_r <= diff[DVS_W-1:0];
        quo_r <= {quo_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_r <= sh[DVS_W-1:0];
        quo_r <= {quo_r[DVD_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = neg_r ? -$signed(quo_ext) : $signed(quo_ext);

endmodule
`default_nettype wire

// ===== hw/rtl/mbsc_core.sv =====
// mbsc_core: sequencer and datapath that shift, clip and check one box at a time
// depends on mbsc_pkg and mbsc_if; drives the shared divider mbsc_div
`default_nettype none
module mbsc_core import mbsc_pkg::*; #(
  parameter int MAX_BOXES = MAX_BOXES_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_t      cfg,
  mbsc_in_if.sink        in_ch,
  mbsc_out_if.source     out_ch,
  output div_req_t       div_req,
  input  wire div_rsp_t  div_rsp
);

  localparam logic [CNTW-1:0] MAXB = CNTW'(MAX_BOXES);

  st_t state_r, state_nxt;
  logic axis_r, axis_nxt;
  logic pend_r;
  logic ok_r;
  logic signed [QW-1:0] x_r, y_r, w_r, h_r;
  logic signed [EW-1:0] lo_r, hi_r;
  logic [CLSW-1:0]  cls_r;
  logic [1:0]       status_r;
  logic [SLOTW-1:0] slot_r;
  logic [FW-1:0]    ox_r, oy_r, ow_r, oh_r;
  logic [CLSW-1:0]  ocls_r;
  logic [CNTW-1:0]  ws_r, rp_r;
  logic             ended_r;

  logic [DIMW-1:0]      wd, hd, dim, cut, shf;
  logic                 qbit;
  logic signed [NW-1:0] dim_s, n, n_abs;
  logic signed [QW-1:0] c_cur, s_cur;
  logic signed [TW-1:0] t;
  logic signed [PW-1:0] p, padj;
  logic signed [EW-1:0] edge_now;
  logic                 minus_edge, div_st, inside_now, accept, ign, is_end;
  logic [CNTW-1:0]      base, ws_e, rp_e;
  logic                 end_e;
  logic signed [SUM_W-1:0] base_ext, q_ext, sum;
  logic signed [QW-1:0] upd;
  logic                 fix_axis2;
  st_t                  fix_next;

  // effective tile size, zero acts as one
  assign wd  = (cfg.img_w == '0) ? DIMW'(1) : cfg.img_w;
  assign hd  = (cfg.img_h == '0) ? DIMW'(1) : cfg.img_h;
  assign dim = axis_r ? hd : wd;
  assign cut = axis_r ? cfg.cut_row : cfg.cut_col;
  assign shf = axis_r ? cfg.y_shift : cfg.x_shift;
  assign qbit = axis_r ? cfg.quadrant[1] : cfg.quadrant[0];
  assign dim_s = $signed(NW'(dim));

  assign c_cur = axis_r ? y_r : x_r;
  assign s_cur = axis_r ? h_r : w_r;

  // edge = trunc((2c -/+ s) * dim / 2^(F+1)) through the one multiplier
  assign minus_edge = (state_r == ST_LO) || (state_r == ST_CHK_LO);
  assign t    = minus_edge ? (TW'(c_cur) <<< 1) - TW'(s_cur)
                           : (TW'(c_cur) <<< 1) + TW'(s_cur);
  assign p    = t * $signed({1'b0, dim});
  assign padj = p[PW-1] ? p + EDGE_RND : p;
  assign edge_now = EW'(padj >>> (FRAC_BITS + 1));

  assign inside_now = !lo_r[EW-1] && (edge_now <= dim_s) && (s_cur > 0) &&
                      (s_cur < ONE_Q) && (c_cur > 0) && (c_cur < ONE_Q);

  // divider operands
  always_comb begin
    case (state_r)
      ST_OFF:             n = qbit ? $signed(NW'(cut)) - $signed(NW'(shf))
                                   : $signed(NW'(cut)) + $signed(NW'(shf)) - dim_s;
      ST_FLO_C, ST_FLO_S: n = lo_r;
      ST_FHI_C, ST_FHI_S: n = hi_r - dim_s;
      default:            n = lo_r;
    endcase
  end
  assign n_abs = n[NW-1] ? -n : n;
  assign div_st = (state_r == ST_OFF) || (state_r == ST_FLO_C) || (state_r == ST_FLO_S) ||
                  (state_r == ST_FHI_C) || (state_r == ST_FHI_S);

  assign div_req.start    = div_st && !pend_r;
  assign div_req.neg      = n[NW-1];
  assign div_req.dividend = {n_abs[MAG_W-1:0], FRAC_BITS'(0)};
  assign div_req.divisor  = ((state_r == ST_FLO_C) || (state_r == ST_FHI_C))
                            ? {dim, 1'b0} : {1'b0, dim};

  // apply quotient to centre or size with saturation
  assign q_ext = SUM_W'(div_rsp.quot);
  always_comb begin
    case (state_r)
      ST_OFF:   begin base_ext = SUM_W'(c_cur); sum = base_ext + q_ext; end
      ST_FLO_S: begin base_ext = SUM_W'(s_cur); sum = base_ext + q_ext; end
      ST_FHI_S: begin base_ext = SUM_W'(s_cur); sum = base_ext - q_ext; end
      default:  begin base_ext = SUM_W'(c_cur); sum = base_ext - q_ext; end
    endcase
  end
  assign upd = satq(sum);

  // list bookkeeping at request accept
  assign accept = in_ch.valid && in_ch.ready;
  assign base   = (cfg.existing_count > MAXB) ? MAXB : cfg.existing_count;
  assign ws_e   = in_ch.start_list ? base : ws_r;
  assign rp_e   = in_ch.start_list ? base : rp_r;
  assign end_e  = in_ch.start_list ? 1'b0 : ended_r;
  assign ign    = end_e || (rp_e >= MAXB);
  assign is_end = (in_ch.box_x == '0);

  assign fix_axis2 = axis_r;
  assign fix_next  = ST_LO;

  // next state
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (ign || is_end) ? ST_OUT : ST_OFF;
          axis_nxt  = 1'b0;
        end
      end
      ST_OFF: begin
        if (div_rsp.done) begin
          state_nxt = axis_r ? ST_LO : ST_OFF;
          axis_nxt  = !axis_r;
        end
      end
      ST_LO: state_nxt = ST_HI;
      ST_HI: begin
        if (lo_r[EW-1]) begin
          state_nxt = ST_FLO_C;
        end else if (edge_now > dim_s) begin
          state_nxt = ST_FHI_C;
        end else begin
          state_nxt = fix_axis2 ? ST_CHK_LO : fix_next;
          axis_nxt  = !axis_r;
        end
      end
      ST_FLO_C: if (div_rsp.done) state_nxt = ST_FLO_S;
      ST_FLO_S: begin
        if (div_rsp.done) begin
          if (hi_r > dim_s) begin
            state_nxt = ST_FHI_C;
          end else begin
            state_nxt = fix_axis2 ? ST_CHK_LO : fix_next;
            axis_nxt  = !axis_r;
          end
        end
      end
      ST_FHI_C: if (div_rsp.done) state_nxt = ST_FHI_S;
      ST_FHI_S: begin
        if (div_rsp.done) begin
          state_nxt = fix_axis2 ? ST_CHK_LO : fix_next;
          axis_nxt  = !axis_r;
        end
      end
      ST_CHK_LO: state_nxt = ST_CHK_HI;
      ST_CHK_HI: begin
        state_nxt = axis_r ? ST_OUT : ST_CHK_LO;
        axis_nxt  = !axis_r;
      end
      ST_OUT: if (out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ch.ready      = (state_r == ST_IDLE);
    out_ch.valid     = (state_r == ST_OUT);
    out_ch.status    = status_r;
    out_ch.slot      = slot_r;
    out_ch.out_x     = ox_r;
    out_ch.out_y     = oy_r;
    out_ch.out_w     = ow_r;
    out_ch.out_h     = oh_r;
    out_ch.out_class = ocls_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= 1'b0;
      pend_r  <= 1'b0;
      ws_r    <= '0;
      rp_r    <= '0;
      ended_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      if (div_req.start) begin
        pend_r <= 1'b1;
      end else if (div_rsp.done) begin
        pend_r <= 1'b0;
      end
      if (accept) begin
        ws_r    <= ws_e;
        rp_r    <= (ign || is_end) ? rp_e : rp_e + CNTW'(1);
        ended_r <= end_e || (!ign && is_end);
      end else if (state_r == ST_CHK_HI && axis_r && ok_r && inside_now) begin
        ws_r <= ws_r + CNTW'(1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          x_r      <= $signed(QW'(in_ch.box_x));
          y_r      <= $signed(QW'(in_ch.box_y));
          w_r      <= $signed(QW'(in_ch.box_w));
          h_r      <= $signed(QW'(in_ch.box_h));
          cls_r    <= in_ch.box_class;
          ok_r     <= 1'b1;
          status_r <= ign ? STAT_IGNORE : STAT_DROP;
          slot_r   <= ign ? '0 : ws_e[SLOTW-1:0];
          ox_r     <= '0;
          oy_r     <= '0;
          ow_r     <= '0;
          oh_r     <= '0;
          ocls_r   <= '0;
        end
      end
      ST_LO, ST_CHK_LO: lo_r <= edge_now;
      ST_HI:            hi_r <= edge_now;
      ST_OFF, ST_FLO_C, ST_FHI_C: begin
        if (div_rsp.done) begin
          if (axis_r) y_r <= upd; else x_r <= upd;
        end
      end
      ST_FLO_S, ST_FHI_S: begin
        if (div_rsp.done) begin
          if (axis_r) h_r <= upd; else w_r <= upd;
        end
      end
      ST_CHK_HI: begin
        ok_r <= ok_r && inside_now;
        if (axis_r && ok_r && inside_now) begin
          status_r <= STAT_KEEP;
          ox_r     <= x_r[QW-1] ? '0 : x_r[FW-1:0];
          oy_r     <= y_r[QW-1] ? '0 : y_r[FW-1:0];
          ow_r     <= w_r[QW-1] ? '0 : w_r[FW-1:0];
          oh_r     <= h_r[QW-1] ? '0 : h_r[FW-1:0];
          ocls_r   <= cls_r;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/mosaic_box_shift_clip.sv =====
// mosaic_box_shift_clip: top level, one box request in, one result out.
// ignored box or end marker: result valid the cycle after accept
// other boxes: 2 to 10 divisions on the 31-step shared divider, plus the lo and hi
// edge multiplies of both axes, for the shift and again for the final check
// one box is processed at a time; the next request is taken after the result handshake
// rst_n is synchronous, active low: registers to reset values, counters cleared.
// depends on mbsc_pkg, mbsc_if, mbsc_regs, mbsc_div, mbsc_core
`default_nettype none
module mosaic_box_shift_clip import mbsc_pkg::*; #(
  parameter int MAX_BOXES = MAX_BOXES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  mbsc_in_if.sink                 in_ch,
  mbsc_out_if.source              out_ch,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  // configuration from the register file, read by the sequencer
  cfg_t     cfg;
  // request and response of the shared divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  // apb register file
  mbsc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // one divider serves offsets and all edge fixes
  mbsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // sequencer, edge multiplier and slot bookkeeping
  mbsc_core #(
    .MAX_BOXES (MAX_BOXES)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

endmodule
`default_nettype wire
